/* sv/ranshi_pkg.sv */
// Shared constants, types and helpers for the ranshi random generator.
// No dependencies; used by ranshi_lcg, ranshi_random_generator and the testbench.
package ranshi_pkg;

  localparam int unsigned DefTableDepth   = 512;
  localparam int unsigned DefWarmupFactor = 128;

  localparam int unsigned WordW = 32;
  localparam int unsigned SeedW = 64;

  // LCG multiplier 6906969069 = 2^32 + LcgMulLo
  localparam logic [WordW-1:0] LcgMulLo = 32'd2612001773;
  localparam logic [SeedW-1:0] LcgInc   = 64'd12345;

  localparam int unsigned RotAmt = 17;

  typedef struct packed {
    logic load;  // take a new seed
    logic run;   // keep stepping the sequence
  } lcg_ctrl_t;

  function automatic logic [WordW-1:0] rotl17(input logic [WordW-1:0] v);
    rotl17 = {v[WordW-RotAmt-1:0], v[WordW-1:WordW-RotAmt]};
  endfunction

endpackage

/* sv/ranshi_random_generator.sv */
// Top level of the ranshi random generator: sequencer, generator datapath, table.
// Depends on ranshi_pkg, ranshi_ram, ranshi_lcg.
//
//   channel  | ports                               | handshake
//   ---------+-------------------------------------+-------------------------------
//   request  | action_i, seed_value_i              | start, busy (taken: start & !busy)
//   result   | random_value_o                      | random_valid_o, one cycle
//
// A next request keeps busy high through a table read and then a write back, and
// the result strobes in the cycle after the write back; the next index needs the new spin.
// A reseed request fills the table with TABLE_DEPTH LCG steps (each two passes of
// the shared multiplier, then the sum), then runs TABLE_DEPTH*WARMUP_FACTOR warm-up
// steps, and gives no result.
// Reset clears control and generator state, but not the table or the result register; the receiver cannot stall.
module ranshi_random_generator #(
  parameter int unsigned TABLE_DEPTH   = ranshi_pkg::DefTableDepth,
  parameter int unsigned WARMUP_FACTOR = ranshi_pkg::DefWarmupFactor
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action_i,
  input  logic [ranshi_pkg::SeedW-1:0] seed_value_i,
  output logic                         random_valid_o,
  output logic [ranshi_pkg::SeedW-1:0] random_value_o
);
  import ranshi_pkg::*;

  localparam int unsigned AW        = $clog2(TABLE_DEPTH);
  localparam int unsigned Half      = TABLE_DEPTH / 2;
  localparam int unsigned WarmSteps = TABLE_DEPTH * WARMUP_FACTOR;
  localparam int unsigned WW        = (WarmSteps > 1) ? $clog2(WarmSteps) : 1;
  localparam logic [AW-1:0] HalfMask = AW'(Half - 1);
  localparam logic [AW-1:0] HalfOff  = AW'(Half);
  localparam logic [AW-1:0] LastIdx  = AW'(TABLE_DEPTH - 1);
  localparam logic [WW-1:0] LastWarm = WW'(WarmSteps - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_CALC = 2'd3;

  logic [1:0]       state_q, state_d;
  logic             warm_q, warm_d;
  logic [WW-1:0]    warm_cnt_q, warm_cnt_d;
  logic [AW-1:0]    fill_idx_q, fill_idx_d;
  logic [WordW-1:0] spin_q, spin_d;
  logic [WordW-1:0] cnt_q, cnt_d;
  logic             half_q, half_d;
  logic             valid_q, valid_d;
  logic [SeedW-1:0] value_q;

  logic             req;
  lcg_ctrl_t        lcg_ctrl;
  logic             lcg_done;
  logic [SeedW-1:0] lcg_next;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic [AW-1:0]    gen_idx;
  logic [WordW-1:0] entry;

  assign req  = start && !busy;
  assign busy = (state_q != S_IDLE);

  assign lcg_ctrl.load = req && action_i;
  assign lcg_ctrl.run  = (state_q == S_FILL);

  ranshi_lcg u_lcg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (lcg_ctrl),
    .seed_i (seed_value_i),
    .done_o (lcg_done),
    .next_o (lcg_next)
  );

  assign gen_idx = (spin_q[AW-1:0] & HalfMask) + (half_q ? HalfOff : '0);

  always_comb begin
    if (state_q == S_FILL) begin
      ram_we    = lcg_done;
      ram_waddr = fill_idx_q;
      ram_wdata = lcg_next[SeedW-1:WordW];
    end else begin
      ram_we    = (state_q == S_CALC);
      ram_waddr = gen_idx;
      ram_wdata = rotl17(entry) ^ spin_q;
    end
  end

  ranshi_ram #(
    .Width (WordW),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (gen_idx),
    .rdata_o (entry)
  );

  always_comb begin
    state_d    = state_q;
    warm_d     = warm_q;
    warm_cnt_d = warm_cnt_q;
    fill_idx_d = fill_idx_q;
    spin_d     = spin_q;
    cnt_d      = cnt_q;
    half_d     = half_q;
    valid_d    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req) begin
          if (action_i) begin
            spin_d     = seed_value_i[WordW-1:0];
            cnt_d      = '0;
            half_d     = 1'b0;
            fill_idx_d = '0;
            warm_cnt_d = '0;
            warm_d     = 1'b1;
            state_d    = S_FILL;
          end else begin
            warm_d  = 1'b0;
            state_d = S_READ;
          end
        end
      end
      S_FILL: begin
        if (lcg_done) begin
          fill_idx_d = fill_idx_q + 1'b1;
          if (fill_idx_q == LastIdx) begin
            state_d = (WarmSteps == 0) ? S_IDLE : S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CALC;
      end
      default: begin
        spin_d = entry + cnt_q;
        cnt_d  = cnt_q + 1'b1;
        half_d = !half_q;
        if (warm_q) begin
          warm_cnt_d = warm_cnt_q + 1'b1;
          state_d    = (warm_cnt_q == LastWarm) ? S_IDLE : S_READ;
        end else begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      warm_q     <= 1'b0;
      warm_cnt_q <= '0;
      fill_idx_q <= '0;
      spin_q     <= '0;
      cnt_q      <= '0;
      half_q     <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      warm_q     <= warm_d;
      warm_cnt_q <= warm_cnt_d;
      fill_idx_q <= fill_idx_d;
      spin_q     <= spin_d;
      cnt_q      <= cnt_d;
      half_q     <= half_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      value_q <= {entry, entry ^ spin_q};
    end
  end

  assign random_valid_o = valid_q;
  assign random_value_o = value_q;

  // a result only follows the write-back step of a next request
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    random_valid_o |-> ($past(state_q) == S_CALC) && !$past(warm_q))
    else $error("result strobe without a next step");

  // the table is never written while an entry is being read
  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !ram_we)
    else $error("table write during read cycle");

  // each read is followed by its write-back step
  a_read_then_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (state_q == S_CALC))
    else $error("read not followed by write-back");

  // the spin only moves in the write-back step or on a reseed request
  a_spin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FILL) || (state_q == S_READ)) |=> $stable(spin_q))
    else $error("spin changed outside a step");

endmodule

/* sv/ranshi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ranshi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ranshi_lcg.sv */
// 64-bit linear congruential sequence stepped with one shared 32x32 multiplier.
// Each step: low-word product, high-word product, then the sum. Depends on ranshi_pkg.
module ranshi_lcg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ranshi_pkg::lcg_ctrl_t                 ctrl_i,
  input  logic [ranshi_pkg::SeedW-1:0]          seed_i,
  output logic                                  done_o,
  output logic [ranshi_pkg::SeedW-1:0]          next_o
);
  import ranshi_pkg::*;

  localparam logic [1:0] PH_LO  = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_SUM = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic [SeedW-1:0]  x_q;
  logic [SeedW-1:0]  p0_q;
  logic [WordW-1:0]  p1_q;
  logic [WordW-1:0]  mul_a;
  logic [SeedW-1:0]  mul_p;
  logic [WordW-1:0]  x_lo, x_hi;

  assign x_lo = x_q[WordW-1:0];
  assign x_hi = x_q[SeedW-1:WordW];

  // the one multiplier: low word first, then high word
  assign mul_a = (phase_q == PH_LO) ? x_lo : x_hi;
  assign mul_p = SeedW'(mul_a) * SeedW'(LcgMulLo);

  // the 2^32 part of the multiplier contributes x_lo to the upper word
  assign next_o = p0_q + {p1_q + x_lo, {WordW{1'b0}}} + LcgInc;
  assign done_o = ctrl_i.run && (phase_q == PH_SUM);

  always_comb begin
    phase_d = phase_q;
    if (!ctrl_i.run) begin
      phase_d = PH_LO;
    end else begin
      unique case (phase_q)
        PH_LO:   phase_d = PH_HI;
        PH_HI:   phase_d = PH_SUM;
        default: phase_d = PH_LO;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LO;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q <= seed_i;
    end else if (done_o) begin
      x_q <= next_o;
    end
    if (ctrl_i.run && phase_q == PH_LO) begin
      p0_q <= mul_p;
    end
    if (ctrl_i.run && phase_q == PH_HI) begin
      p1_q <= mul_p[WordW-1:0];
    end
  end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for ranshi_random_generator: directed and random reseed/next requests.
// Holds its own bit-accurate generator predictor; depends on ranshi_pkg and the block's RTL.
module testbench;

  localparam int unsigned TableDepth   = ranshi_pkg::DefTableDepth;
  localparam int unsigned WarmupFactor = ranshi_pkg::DefWarmupFactor;
  localparam int unsigned HalfDepth    = TableDepth / 2;
  localparam int unsigned WordW        = ranshi_pkg::WordW;
  localparam int unsigned SeedW        = ranshi_pkg::SeedW;

  localparam logic ActNext   = 1'b0;
  localparam logic ActReseed = 1'b1;

  localparam bit [SeedW-1:0] SeqMul = 64'd6906969069;
  localparam bit [SeedW-1:0] SeqAdd = 64'd12345;

  localparam int unsigned MaxGap       = 14;
  localparam int unsigned NextPerRound = 310;

  typedef struct {
    logic             action;
    logic [SeedW-1:0] seed;
  } request_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             action_i = ActNext;
  logic [SeedW-1:0] seed_value_i = '0;
  logic             random_valid_o;
  logic [SeedW-1:0] random_value_o;

  request_t         pending_requests[$];
  logic [SeedW-1:0] expected_values[$];
  request_t         head_req;
  logic [SeedW-1:0] want_value;
  int unsigned      wait_left;
  bit               no_gap_run;
  int unsigned      mismatches;

  // predictor state
  bit [WordW-1:0] pool[TableDepth];
  bit [WordW-1:0] mix_word;
  bit             hi_bank;
  bit [WordW-1:0] draw_count;

  ranshi_random_generator #(
    .TABLE_DEPTH  (TableDepth),
    .WARMUP_FACTOR(WarmupFactor)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .seed_value_i  (seed_value_i),
    .random_valid_o(random_valid_o),
    .random_value_o(random_value_o)
  );

  always #5 clk_i = ~clk_i;

  // One generator step: read, emit, write back rotated entry, advance spin state.
  function automatic bit [SeedW-1:0] next_word();
    int unsigned    idx;
    bit [WordW-1:0] e;
    bit [WordW-1:0] low;
    idx = (int'(mix_word) & (HalfDepth - 1)) + (hi_bank ? HalfDepth : 0);
    e = pool[idx];
    low = e ^ mix_word;
    pool[idx] = {e[WordW-18:0], e[WordW-1:WordW-17]} ^ mix_word;
    mix_word = e + draw_count;
    draw_count = draw_count + 1;
    hi_bank = ~hi_bank;
    return {e, low};
  endfunction

  task automatic predict_request(input logic act, input logic [SeedW-1:0] seed);
    bit [SeedW-1:0] seq;
    if (act == ActReseed) begin
      seq = seed;
      mix_word = seed[WordW-1:0];
      hi_bank = 1'b0;
      draw_count = '0;
      for (int i = 0; i < TableDepth; i++) begin
        seq = SeqMul * seq + SeqAdd;
        pool[i] = seq[SeedW-1:WordW];
      end
      for (int n = 0; n < TableDepth * WarmupFactor; n++) void'(next_word());
    end else begin
      expected_values.push_back(next_word());
    end
  endtask

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 31) == 0) no_gap_run = ~no_gap_run;
    return no_gap_run ? 0 : $urandom_range(0, MaxGap);
  endfunction

  task automatic report_mismatch(input string what, input logic [SeedW-1:0] got,
                                 input logic [SeedW-1:0] want);
    // keep the log bounded if everything goes wrong
    if (mismatches < 200)
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic add_request(input logic act, input logic [SeedW-1:0] seed);
    request_t r;
    r.action = act;
    r.seed = seed;
    pending_requests.push_back(r);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      action_i <= ActNext;
      seed_value_i <= '0;
      wait_left = 0;
    end else begin
      if (start && !busy) begin
        predict_request(action_i, seed_value_i);
        wait_left = pick_gap();
      end
      if (!start || !busy) begin
        if (wait_left > 0 || pending_requests.size() == 0) begin
          if (wait_left > 0) wait_left--;
          // idle: noise on the payload must be ignored
          start <= 1'b0;
          action_i <= 1'($urandom_range(0, 1));
          seed_value_i <= {$urandom, $urandom};
        end else begin
          head_req = pending_requests.pop_front();
          start <= 1'b1;
          action_i <= head_req.action;
          seed_value_i <= head_req.seed;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && random_valid_o) begin
      if (expected_values.size() == 0) begin
        report_mismatch("unexpected result", random_value_o, '0);
      end else begin
        want_value = expected_values.pop_front();
        if (random_value_o !== want_value)
          report_mismatch("random_value", random_value_o, want_value);
      end
    end
  end

  initial begin
    mismatches = 0;
    no_gap_run = 1'b0;

    // directed: seed extremes, then enough draws to cover both table halves
    add_request(ActReseed, '1);
    repeat (6) add_request(ActNext, {$urandom, $urandom});
    add_request(ActReseed, '0);
    repeat (6) add_request(ActNext, {$urandom, $urandom});

    // random rounds; seed field on next requests is don't-care noise
    repeat (3) begin
      add_request(ActReseed, {$urandom, $urandom});
      repeat (NextPerRound) add_request(ActNext, {$urandom, $urandom});
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || start) @(posedge clk_i);
    while (expected_values.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #40000000;
    $display("status: fail");
    $finish;
  end

endmodule

/* ranshi_random_generator.f */
sv/ranshi_pkg.sv
sv/ranshi_ram.sv
sv/ranshi_lcg.sv
sv/ranshi_random_generator.sv
sim/testbench.sv
